// File: rtl/core/base64url_stream_codec_assert.svh
// Assertion macros used by the codec checker.
`ifndef BASE64URL_STREAM_CODEC_ASSERT_SVH
`define BASE64URL_STREAM_CODEC_ASSERT_SVH

// Check cons in the same cycle as ante, outside reset.
`define B64U_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante, outside reset.
`define B64U_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante, reset included.
`define B64U_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/b64u_pkg.sv
package b64u_pkg;

    // One result word as it sits in the output queue.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       last;
    } t_res;

    // Configuration register byte addresses.
    localparam logic [1:0] REG_MODE = 2'd0;

    // Values of the mode register.
    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

endpackage

// File: rtl/core/b64u_step.sv
module b64u_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic             i_clr,
    input  logic             i_mode,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output b64u_pkg::t_res   o_res0,
    output b64u_pkg::t_res   o_res1,
    output logic [1:0]       o_cnt
);
    import b64u_pkg::*;

    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return CH_UP_A + w;
        end else if (v < 6'd52) begin
            return CH_LO_A + w - 8'd26;
        end else if (v < 6'd62) begin
            return CH_ZERO + w - 8'd52;
        end else if (v == 6'd62) begin
            return CH_DASH;
        end
        return CH_UNDER;
    endfunction

    // Bit 6 set means the character is outside the alphabet.
    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            return {1'b0, 6'(c - CH_UP_A)};
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            return {1'b0, 6'(c - CH_LO_A + 8'd26)};
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            return {1'b0, 6'(c - CH_ZERO + 8'd52)};
        end else if (c == CH_DASH) begin
            return 7'd62;
        end else if (c == CH_UNDER) begin
            return 7'd63;
        end
        return 7'd64;
    endfunction

    logic [5:0]  r_buf;
    logic [2:0]  r_pend;
    logic [5:0]  n_buf;
    logic [2:0]  n_pend;

    logic [2:0]  p;
    logic [5:0]  keep;
    logic [11:0] enc_w;
    logic [11:0] dec_w;
    logic [6:0]  sx;
    t_res        res0;
    t_res        res1;
    logic [1:0]  cnt;

    always_comb begin
        p     = (r_pend > 3'd6) ? 3'd6 : r_pend;
        keep  = r_buf & 6'((7'd1 << p) - 7'd1);
        enc_w = {keep[3:0], i_byte};
        sx    = char_to_sextet(i_byte);
        dec_w = {keep, sx[5:0]};
        res0  = '{data_byte: 8'd0, data_valid: 1'b1, last: 1'b0};
        res1  = '{data_byte: 8'd0, data_valid: 1'b1, last: 1'b0};
        cnt   = 2'd0;
        n_buf = keep;
        n_pend = p;

        if (i_mode == MODE_ENC) begin
            case (p)
                3'd0: begin
                    res0.data_byte = sextet_to_char(enc_w[7:2]);
                    cnt    = 2'd1;
                    n_pend = 3'd2;
                    n_buf  = {4'b0, enc_w[1:0]};
                end
                3'd2: begin
                    res0.data_byte = sextet_to_char(enc_w[9:4]);
                    cnt    = 2'd1;
                    n_pend = 3'd4;
                    n_buf  = {2'b0, enc_w[3:0]};
                end
                default: begin
                    res0.data_byte = sextet_to_char(enc_w[11:6]);
                    res1.data_byte = sextet_to_char(enc_w[5:0]);
                    cnt    = 2'd2;
                    n_pend = 3'd0;
                    n_buf  = 6'd0;
                end
            endcase
            // flush leftover bits, zero-filled on the right
            if (i_last && n_pend != 3'd0) begin
                res1.data_byte = (n_pend == 3'd2) ? sextet_to_char({n_buf[1:0], 4'b0})
                                                  : sextet_to_char({n_buf[3:0], 2'b0});
                cnt = 2'd2;
            end
        end else if (!sx[6]) begin
            case (p)
                3'd2: begin
                    res0.data_byte = dec_w[7:0];
                    cnt    = 2'd1;
                    n_pend = 3'd0;
                    n_buf  = 6'd0;
                end
                3'd4: begin
                    res0.data_byte = dec_w[9:2];
                    cnt    = 2'd1;
                    n_pend = 3'd2;
                    n_buf  = {4'b0, dec_w[1:0]};
                end
                3'd6: begin
                    res0.data_byte = dec_w[11:4];
                    cnt    = 2'd1;
                    n_pend = 3'd4;
                    n_buf  = {2'b0, dec_w[3:0]};
                end
                default: begin
                    n_pend = 3'd6;
                    n_buf  = sx[5:0];
                end
            endcase
        end

        if (i_last) begin
            if (cnt == 2'd0) begin
                // empty end marker
                res0 = '{data_byte: 8'd0, data_valid: 1'b0, last: 1'b1};
                cnt  = 2'd1;
            end else if (cnt == 2'd1) begin
                res0.last = 1'b1;
            end else begin
                res1.last = 1'b1;
            end
            n_pend = 3'd0;
            n_buf  = 6'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_buf  <= 6'd0;
            r_pend <= 3'd0;
        end else if (i_go) begin
            r_buf  <= n_buf;
            r_pend <= n_pend;
        end
    end

    assign o_res0 = res0;
    assign o_res1 = res1;
    assign o_cnt  = cnt;

endmodule

// File: rtl/core/b64u_outq.sv
module b64u_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64u_pkg::t_res   i_res0,
    input  b64u_pkg::t_res   i_res1,
    input  logic [1:0]       i_cnt,
    output logic             o_room,
    output b64u_pkg::t_res   o_res,
    output logic             o_valid,
    input  logic             i_ready
);
    import b64u_pkg::*;

    t_res       r_slot [3];
    t_res       n_slot [3];
    t_res       shifted [3];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic [1:0] base;
    logic       pop;

    always_comb begin
        pop        = (r_cnt != 2'd0) && i_ready;
        base       = r_cnt - {1'b0, pop};
        // advance the queue on a pop
        shifted[0] = pop ? r_slot[1] : r_slot[0];
        shifted[1] = pop ? r_slot[2] : r_slot[1];
        shifted[2] = r_slot[2];
        for (int i = 0; i < 3; i++) begin
            n_slot[i] = shifted[i];
            if (i_push && 2'(i) == base && i_cnt != 2'd0) begin
                n_slot[i] = i_res0;
            end
            if (i_push && 2'(i) == base + 2'd1 && i_cnt == 2'd2) begin
                n_slot[i] = i_res1;
            end
        end
        n_cnt = base + (i_push ? i_cnt : 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        for (int i = 0; i < 3; i++) begin
            r_slot[i] <= n_slot[i];
        end
    end

    assign o_room  = (r_cnt <= 2'd1);
    assign o_res   = r_slot[0];
    assign o_valid = (r_cnt != 2'd0);

endmodule

// File: rtl/core/base64url_stream_codec.sv
// Streaming URL-safe base64 codec, no '=' padding.
// Input channel: i_item_valid / o_item_ready carry one word (i_in_byte, i_in_last).
// Result channel: o_res_valid / i_res_ready carry one word
// (o_out_byte, o_out_valid, o_out_last); o_out_valid low marks an empty end word.
// APB port: register at address 0, bit 0 selects mode (0 encode, 1 decode);
// a write also empties the bit buffer. Write only while the block is idle.
// An accepted word waits in the input register until the queue has room, then
// passes through the step logic into the three-entry result queue, which
// sends one result per cycle while the receiver is ready. A word moves on when
// the queue holds at most one result, so decode, which makes at most one result
// per word, takes a word every cycle while the receiver is ready, and encode,
// making one or two characters per byte, holds back the byte after one that makes two.
// Reset empties the input register, the queue and the bit buffer and selects
// encode mode. When the receiver stalls, the head result holds, the queue fills
// to two or three results, and o_item_ready drops once the input register is full.
module base64url_stream_codec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_item_valid,
    output logic        o_item_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_valid,
    output logic        o_out_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import b64u_pkg::*;

    logic       r_mode;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       cfg_wr;
    logic       room;
    logic       go;
    t_res       res0;
    t_res       res1;
    t_res       head;
    logic [1:0] cnt;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_MODE);
    assign prdata = (paddr == REG_MODE) ? {31'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENC;
        end else if (cfg_wr) begin
            r_mode <= pwdata[0];
        end
    end

    assign go           = r_in_valid && room;
    assign o_item_ready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_item_ready) begin
            r_in_valid <= i_item_valid;
        end
        if (o_item_ready && i_item_valid) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    b64u_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_clr   (cfg_wr),
        .i_mode  (r_mode),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_cnt   (cnt)
    );

    b64u_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (go),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_cnt   (cnt),
        .o_room  (room),
        .o_res   (head),
        .o_valid (o_res_valid),
        .i_ready (i_res_ready)
    );

    assign o_out_byte  = head.data_byte;
    assign o_out_valid = head.data_valid;
    assign o_out_last  = head.last;

endmodule

// File: rtl/core/b64u_checker.sv
`include "base64url_stream_codec_assert.svh"

module b64u_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_res_valid,
    input logic       i_res_ready,
    input logic [7:0] o_out_byte,
    input logic       o_out_valid,
    input logic       o_out_last
);

    // a stalled result word holds
    `B64U_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, o_res_valid && !i_res_ready,
        o_res_valid && $stable(o_out_byte) && $stable(o_out_valid) && $stable(o_out_last),
        "result word changed while stalled")

    // an empty word only ever closes a message and carries zero
    `B64U_ASSERT_NOW(a_marker, i_clk, i_rst_n, o_res_valid && !o_out_valid,
        o_out_last && (o_out_byte == 8'd0), "malformed end marker")

    // reset drains the result side
    `B64U_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_res_valid,
        "result valid right after reset")

endmodule

bind base64url_stream_codec b64u_checker u_b64u_checker (.*);
